/* hdl/gsa_pkg.sv */
// Shared types, constants and lookup tables for the gas sensor averaging and ppm unit.
`default_nettype none
package gsa_pkg;

  localparam int SumW     = 28;
  localparam int CntW     = 16;
  localparam int SampW    = 12;
  localparam int TabBits  = 6;
  localparam int TabN     = 1 << TabBits;
  localparam int LgFrac   = 24;
  localparam int DivNumW  = 56;
  localparam int DivDenW  = 24;
  localparam int DivCntW  = $clog2(DivNumW);
  localparam int MulAW    = 33;
  localparam int MulBW    = 32 - TabBits;
  localparam int ProdW    = MulAW + MulBW;

  // register indexes
  localparam logic [2:0] RegSamples  = 3'd0;
  localparam logic [2:0] RegAdcWidth = 3'd1;
  localparam logic [2:0] RegSupply   = 3'd2;
  localparam logic [2:0] RegLoad     = 3'd3;
  localparam logic [2:0] RegCleanAir = 3'd4;

  localparam logic [15:0] SamplesRst = 16'd16;
  localparam logic [1:0]  AdcCodeRst = 2'd3;
  localparam logic [19:0] SupplyRst  = 20'd327680;
  localparam logic [23:0] LoadRst    = 24'd655360;
  localparam logic [23:0] CleanRst   = 24'd655360;

  localparam logic [12:0] VoltScale  = 13'd4851;     // 3.3 * 14.7 / 10, times 1000
  localparam logic [19:0] CoefQ16    = 20'd756469;   // 11.5428 in Q.16
  localparam logic [15:0] ExpoQ16    = 16'd42920;    // 0.6549 in Q.16
  localparam logic [21:0] WinMin     = 22'd66;       // smallest value with x*1000 > 2^16
  localparam logic [11:0] AvgMax     = 12'd4095;

  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [CntW-1:0] n;
  } job_t;

  typedef struct packed {
    logic [15:0] samples;
    logic [1:0]  adc_code;
    logic [19:0] vc;
    logic [23:0] rl;
    logic [23:0] r0;
  } cfg_t;

  typedef enum logic [4:0] {
    BkIdle, BkAvg, BkVMul, BkVGo, BkV, BkRsMul, BkRsGo, BkRs, BkRatGo, BkRat,
    BkL1Mul, BkNLoad, BkNorm, BkLInt, BkLSum, BkYMul, BkY, BkEMul, BkExp, BkOut
  } back_state_e;

  // 1000 * full scale
  function automatic logic [21:0] volt_den(input logic [1:0] code);
    logic [21:0] d;
    unique case (code)
      2'd0:    d = 22'd511000;
      2'd1:    d = 22'd1023000;
      2'd2:    d = 22'd2047000;
      default: d = 22'd4095000;
    endcase
    return d;
  endfunction

  typedef logic [24:0] log_tab_t [TabN+1];
  typedef logic [31:0] exp_tab_t [TabN+1];

  // log2(1+i/2^T) in Q.24 by repeated squaring
  function automatic log_tab_t build_log_tab();
    log_tab_t    t;
    logic [63:0] m;
    logic [24:0] r;
    for (int i = 0; i < TabN; i++) begin
      m = (64'd1 << 30) + (64'(i) << (30 - TabBits));
      r = '0;
      for (int k = 0; k < LgFrac; k++) begin
        m = (m * m) >> 30;
        r = {r[23:0], 1'b0};
        if (m >= (64'd1 << 31)) begin
          r[0] = 1'b1;
          m = m >> 1;
        end
      end
      t[i] = r;
    end
    t[TabN] = 25'd1 << LgFrac;
    return t;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v0);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v = v0;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^(i/2^T) in Q.30 from products of repeated square roots
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    logic [63:0] roots [TabBits+1];
    logic [63:0] acc;
    roots[0] = 64'd1 << 31;
    for (int k = 1; k <= TabBits; k++) roots[k] = isqrt64(roots[k-1] << 30);
    for (int i = 0; i < TabN; i++) begin
      acc = 64'd1 << 30;
      for (int j = 0; j < TabBits; j++) begin
        if (((i >> j) & 1) != 0) acc = (acc * roots[TabBits-j]) >> 30;
      end
      t[i] = acc[31:0];
    end
    t[TabN] = 32'd1 << 31;
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();
  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

/* hdl/gsa_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module gsa_div import gsa_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [DivNumW-1:0] num_i,
  input  wire logic [DivDenW-1:0] den_i,
  output logic                    done_o,
  output logic [DivNumW-1:0]      quot_o
);

  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivDenW-1:0] den_q;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               run_q, run_d, done_q, done_d;
  logic [DivDenW:0]   trial;

  assign trial = {rem_q, quo_q[DivNumW-1]};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DivDenW'(trial - {1'b0, den_q});
        quo_d = {quo_q[DivNumW-2:0], 1'b1};
      end else begin
        rem_d = trial[DivDenW-1:0];
        quo_d = {quo_q[DivNumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivNumW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

/* hdl/gsa_front.sv */
// Sample accumulator: sums samples and posts one job per completed group.
`default_nettype none
module gsa_front import gsa_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [SampW-1:0] sample_i,
  input  wire logic [CntW-1:0]  n_i,
  output logic                  push_o,
  output job_t                  job_o,
  input  wire logic             push_ready_i
);

  logic [SumW-1:0] sum_q, sum_d, sum_new;
  logic [CntW-1:0] seen_q, seen_d, seen_new;
  logic            accept, complete;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign sum_new    = sum_q + SumW'(sample_i);
  assign seen_new   = seen_q + 1'b1;
  assign complete   = seen_new >= n_i;

  always_comb begin
    sum_d  = sum_q;
    seen_d = seen_q;
    if (accept) begin
      sum_d  = complete ? '0 : sum_new;
      seen_d = complete ? '0 : seen_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      seen_q <= '0;
    end else begin
      sum_q  <= sum_d;
      seen_q <= seen_d;
    end
  end

  assign push_o    = accept && complete;
  assign job_o.sum = sum_new;
  assign job_o.n   = n_i;

endmodule
`default_nettype wire

/* hdl/gsa_fifo.sv */
// Two-entry job queue between the accumulator and the compute sequencer.
`default_nettype none
module gsa_fifo import gsa_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_data_i,
  output logic      push_ready_o,
  input  wire logic pop_i,
  output logic      pop_valid_o,
  output job_t      pop_data_o
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

/* hdl/gsa_back.sv */
// Compute sequencer: average, voltage, Rs, ratio and power-law ppm for one job.
`default_nettype none
module gsa_back import gsa_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic job_valid_i,
  input  wire job_t job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic [11:0] avg_raw_o,
  output logic [18:0] sensor_volts_o,
  output logic [39:0] rs_kohm_o,
  output logic [31:0] rs_ratio_o,
  output logic [31:0] ppm_value_o,
  output logic        rs_valid_o,
  output logic        ppm_valid_o
);

  back_state_e state_q, state_d;

  logic               div_start, div_done;
  logic [DivNumW-1:0] div_num, div_quot;
  logic [DivDenW-1:0] div_den;
  logic [MulAW-1:0]   mul_a;
  logic [MulBW-1:0]   mul_b;
  logic [ProdW-1:0]   prod_q;

  logic [11:0] avg_q;
  logic [21:0] v_q;
  logic [39:0] rs_q;
  logic [31:0] ratio_q, ppm_q;
  logic        rs_ok_q, ppm_ok_q, second_q;
  logic [63:0] norm_q;
  logic [5:0]  e_q;
  logic [30:0] lg1_q;
  logic        l_neg_q;
  logic [32:0] l_mag_q;
  logic signed [33:0] y_q;
  logic        out_valid_q;

  // datapath helpers
  logic                window_ok;
  logic [TabBits-1:0]  lidx, eidx;
  logic [TabBits:0]    lidx1, eidx1;
  logic [24:0]         log_lo, log_diff;
  logic [30:0]         lgv;
  logic signed [32:0]  l_val;
  logic [47:0]         yp;
  logic signed [33:0]  y_calc;
  logic [31:0]         exp_lo, exp_diff;
  logic [32:0]         m_val;
  logic [9:0]          yi;
  logic [33:0]         ppm_wide;

  gsa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign window_ok = (div_quot >= DivNumW'(WinMin)) && (div_quot < DivNumW'(cfg_i.vc));

  assign lidx     = norm_q[62 -: TabBits];
  assign lidx1    = {1'b0, lidx} + 1'b1;
  assign log_lo   = LOG_TAB[lidx];
  assign log_diff = LOG_TAB[lidx1] - log_lo;
  assign lgv      = {1'b0, e_q, 24'd0} + 31'(log_lo) + 31'(prod_q >> (32 - TabBits));
  assign l_val    = $signed({2'b0, lg1_q}) - $signed({2'b0, lgv}) - 33'sd268435456;

  assign yp     = prod_q[47:0];
  assign y_calc = l_neg_q ? 34'sd268435456 - $signed({2'b0, 32'((yp + 48'hFFFF) >> 16)})
                          : 34'sd268435456 + $signed({2'b0, 32'(yp >> 16)});

  assign yi       = y_q[33:24];
  assign eidx     = y_q[23 -: TabBits];
  assign eidx1    = {1'b0, eidx} + 1'b1;
  assign exp_lo   = EXP_TAB[eidx];
  assign exp_diff = EXP_TAB[eidx1] - exp_lo;
  assign m_val    = 33'(exp_lo) + 33'(prod_q >> (24 - TabBits));

  always_comb begin
    if (yi >= 10'd30) ppm_wide = {1'b0, m_val} << (yi[4:0] - 5'd30);
    else ppm_wide = {1'b0, m_val} >> (5'd30 - yi[4:0]);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle:  if (job_valid_i) state_d = BkAvg;
      BkAvg:   if (div_done) state_d = BkVMul;
      BkVMul:  state_d = BkVGo;
      BkVGo:   state_d = BkV;
      BkV:     if (div_done) state_d = window_ok ? BkRsMul : BkOut;
      BkRsMul: state_d = BkRsGo;
      BkRsGo:  state_d = BkRs;
      BkRs:    if (div_done) state_d = BkRatGo;
      BkRatGo: state_d = BkRat;
      BkRat:   if (div_done) state_d = (rs_q >= 40'(WinMin)) ? BkL1Mul : BkOut;
      BkL1Mul: state_d = BkNLoad;
      BkNLoad: state_d = BkNorm;
      BkNorm:  if (norm_q[63]) state_d = BkLInt;
      BkLInt:  state_d = BkLSum;
      BkLSum:  state_d = second_q ? BkYMul : BkNLoad;
      BkYMul:  state_d = BkY;
      BkY:     state_d = y_calc[33] ? BkOut : BkEMul;
      BkEMul:  state_d = BkExp;
      BkExp:   state_d = BkOut;
      BkOut:   if (!out_valid_q || out_ready_i) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  // control outputs: divider start, multiplier operands, queue pop
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    mul_a     = '0;
    mul_b     = '0;
    pop_o     = 1'b0;
    unique case (state_q)
      BkIdle: begin
        pop_o     = job_valid_i;
        div_start = job_valid_i;
        div_num   = DivNumW'(job_i.sum);
        div_den   = DivDenW'(job_i.n);
      end
      BkVMul: begin
        mul_a = MulAW'(avg_q);
        mul_b = MulBW'(VoltScale);
      end
      BkVGo: begin
        div_start = 1'b1;
        div_num   = {prod_q[39:0], 16'd0};
        div_den   = DivDenW'(volt_den(cfg_i.adc_code));
      end
      BkRsMul: begin
        mul_a = MulAW'(cfg_i.vc - v_q[19:0]);
        mul_b = MulBW'(cfg_i.rl);
      end
      BkRsGo: begin
        div_start = 1'b1;
        div_num   = DivNumW'(prod_q[43:0]);
        div_den   = DivDenW'(v_q);
      end
      BkRatGo: begin
        div_start = 1'b1;
        div_num   = {rs_q, 16'd0};
        div_den   = cfg_i.r0;
      end
      BkL1Mul: begin
        mul_a = MulAW'(cfg_i.r0);
        mul_b = MulBW'(CoefQ16);
      end
      BkLInt: begin
        mul_a = MulAW'(log_diff);
        mul_b = norm_q[62-TabBits -: MulBW];
      end
      BkYMul: begin
        mul_a = l_mag_q;
        mul_b = MulBW'(ExpoQ16);
      end
      BkEMul: begin
        mul_a = MulAW'(exp_diff);
        mul_b = MulBW'(y_q[23-TabBits:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BkOut && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      BkIdle: begin
        rs_q     <= '0;
        ratio_q  <= '0;
        ppm_q    <= '0;
        rs_ok_q  <= 1'b0;
        ppm_ok_q <= 1'b0;
        second_q <= 1'b0;
      end
      BkAvg: if (div_done) avg_q <= (|div_quot[DivNumW-1:12]) ? AvgMax : div_quot[11:0];
      BkV:   if (div_done) v_q <= div_quot[21:0];
      BkRs: if (div_done) begin
        rs_q    <= (|div_quot[DivNumW-1:40]) ? '1 : div_quot[39:0];
        rs_ok_q <= 1'b1;
      end
      BkRat: if (div_done) ratio_q <= (|div_quot[DivNumW-1:32]) ? '1 : div_quot[31:0];
      BkNLoad: begin
        norm_q <= second_q ? 64'(rs_q) : 64'(prod_q);
        e_q    <= 6'd63;
      end
      BkNorm: if (!norm_q[63]) begin
        norm_q <= {norm_q[62:0], 1'b0};
        e_q    <= e_q - 1'b1;
      end
      BkLSum: begin
        if (!second_q) begin
          lg1_q    <= lgv;
          second_q <= 1'b1;
        end else begin
          l_neg_q <= l_val[32];
          l_mag_q <= l_val[32] ? 33'(-l_val) : 33'(l_val);
        end
      end
      BkY: begin
        y_q      <= y_calc;
        ppm_ok_q <= 1'b1;
      end
      BkExp: begin
        if (yi >= 10'd32 || (|ppm_wide[33:32])) begin
          ppm_q    <= '1;
          ppm_ok_q <= 1'b0;
        end else begin
          ppm_q <= ppm_wide[31:0];
        end
      end
      BkOut: if (!out_valid_q || out_ready_i) begin
        avg_raw_o      <= avg_q;
        sensor_volts_o <= (v_q > 22'h7FFFF) ? 19'h7FFFF : v_q[18:0];
        rs_kohm_o      <= rs_q;
        rs_ratio_o     <= ratio_q;
        ppm_value_o    <= ppm_q;
        rs_valid_o     <= rs_ok_q;
        ppm_valid_o    <= ppm_ok_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

/* hdl/gas_sensor_average_and_ppm_unit.sv */
// Top level of the gas sensor averaging and ppm unit.
`default_nettype none
// Takes one 12-bit ADC sample per transfer, one per cycle while the job queue has room, and
// after samples_per_reading samples emits one reading: truncated average, divider-corrected
// sensor voltage (Q3.16), load-model resistance Rs (Q24.16), Rs/R0 (Q16.16) and the power-law
// concentration (Q16.16 ppm), each saturating. The compute sequencer ends a reading early
// when the voltage falls outside the window or Rs is too small for the power law; otherwise
// a reading takes four passes of the shared bit-serial divider, two leading-one searches,
// plus multiplies and table steps.
// A two-entry queue between the accumulator and the sequencer holds finished sample groups,
// so the input side only stalls when two groups wait behind the reading being computed.
// Zero in samples_per_reading, supply_volts, load_kohm or clean_air_kohm selects the reset
// value of that register. Configuration writes are never stalled and are meant
// to happen while the unit is idle.
module gas_sensor_average_and_ppm_unit import gsa_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [11:0] sample_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [11:0]      avg_raw_o,
  output logic [18:0]      sensor_volts_o,
  output logic [39:0]      rs_kohm_o,
  output logic [31:0]      rs_ratio_o,
  output logic [31:0]      ppm_value_o,
  output logic             rs_valid_o,
  output logic             ppm_valid_o
);

  // configuration registers, as written
  logic [15:0] samples_q;
  logic [1:0]  adc_code_q;
  logic [19:0] vc_q;
  logic [23:0] rl_q;
  logic [23:0] r0_q;
  cfg_t        cfg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q  <= SamplesRst;
      adc_code_q <= AdcCodeRst;
      vc_q       <= SupplyRst;
      rl_q       <= LoadRst;
      r0_q       <= CleanRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegSamples:  samples_q  <= cfg_data_i[15:0];
        RegAdcWidth: adc_code_q <= cfg_data_i[1:0];
        RegSupply:   vc_q       <= cfg_data_i[19:0];
        RegLoad:     rl_q       <= cfg_data_i;
        RegCleanAir: r0_q       <= cfg_data_i;
        default: ;   // unmapped index: write dropped
      endcase
    end
  end

  // zero falls back to the reset value, except for the ADC width code
  assign cfg.samples  = (samples_q == '0) ? SamplesRst : samples_q;
  assign cfg.adc_code = adc_code_q;
  assign cfg.vc       = (vc_q == '0) ? SupplyRst : vc_q;
  assign cfg.rl       = (rl_q == '0) ? LoadRst : rl_q;
  assign cfg.r0       = (r0_q == '0) ? CleanRst : r0_q;

  logic push, push_ready, pop, job_valid;
  job_t push_job, pop_job;

  gsa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .n_i          (cfg.samples),
    .push_o       (push),
    .job_o        (push_job),
    .push_ready_i (push_ready)
  );

  gsa_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_job),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (job_valid),
    .pop_data_o   (pop_job)
  );

  gsa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .job_valid_i    (job_valid),
    .job_i          (pop_job),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .avg_raw_o      (avg_raw_o),
    .sensor_volts_o (sensor_volts_o),
    .rs_kohm_o      (rs_kohm_o),
    .rs_ratio_o     (rs_ratio_o),
    .ppm_value_o    (ppm_value_o),
    .rs_valid_o     (rs_valid_o),
    .ppm_valid_o    (ppm_valid_o)
  );

  // queue never takes a job it has no room for
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> push_ready) else $error("job queue overflow");

  // pop only when a job is waiting
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> job_valid) else $error("job queue underflow");

  // outside the voltage window all derived fields read zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rs_valid_o |-> rs_kohm_o == '0 && rs_ratio_o == '0 &&
                                   ppm_value_o == '0 && !ppm_valid_o)
    else $error("derived fields set without valid Rs");

  // a saturated ppm is never flagged valid
  a_ppm_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ppm_valid_o |-> ppm_value_o != 32'hFFFF_FFFF && rs_valid_o)
    else $error("saturated ppm flagged valid");

endmodule
`default_nettype wire

/* sim/gsa_checker.sv */
// Checker for the gas sensor unit: watches all channels, predicts each reading and compares.
module gsa_checker import gsa_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [11:0] sample_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [11:0] avg_raw_i,
  input  wire logic [18:0] sensor_volts_i,
  input  wire logic [39:0] rs_kohm_i,
  input  wire logic [31:0] rs_ratio_i,
  input  wire logic [31:0] ppm_value_i,
  input  wire logic        rs_valid_i,
  input  wire logic        ppm_valid_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [11:0] avg;
    logic [18:0] volts;
    logic [39:0] rs;
    logic [31:0] ratio;
    logic [31:0] ppm;
    logic        rs_ok;
    logic        ppm_ok;
  } reading_t;

  reading_t readings_due[$];

  logic [27:0] grp_sum;
  logic [15:0] grp_cnt;
  logic [15:0] spr_q;
  logic [1:0]  code_q;
  logic [19:0] vc_q;
  logic [23:0] rl_q;
  logic [23:0] r0_q;

  logic [31:0] lg_tab [0:TabN];
  logic [63:0] ex_tab [0:TabN];

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] t;
    res = '0;
    for (int b = 31; b >= 0; b--) begin
      t = res | (64'd1 << b);
      if (t * t <= x) res = t;
    end
    return res;
  endfunction

  initial begin
    logic [63:0] m;
    logic [31:0] r;
    logic [63:0] rt [0:TabBits];
    logic [63:0] acc;
    for (int i = 0; i < TabN; i++) begin
      m = (64'd1 << 30) + (64'(i) << (30 - TabBits));
      r = '0;
      for (int k = 0; k < 24; k++) begin
        m = (m * m) >> 30;
        r = r << 1;
        if (m >= (64'd1 << 31)) begin
          r = r | 32'd1;
          m = m >> 1;
        end
      end
      lg_tab[i] = r;
    end
    lg_tab[TabN] = 32'd1 << 24;
    rt[0] = 64'd1 << 31;
    for (int k = 1; k <= TabBits; k++) rt[k] = int_sqrt(rt[k-1] << 30);
    for (int i = 0; i < TabN; i++) begin
      acc = 64'd1 << 30;
      for (int j = 0; j < TabBits; j++)
        if ((i >> j) & 1) acc = (acc * rt[TabBits-j]) >> 30;
      ex_tab[i] = acc;
    end
    ex_tab[TabN] = 64'd1 << 31;
  end

  // log2 in Q.24, table on the top mantissa bits plus linear interpolation
  function automatic longint log2_q24(input logic [63:0] x);
    int          e;
    logic [63:0] nf;
    logic [63:0] rem;
    logic [63:0] lo;
    logic [63:0] hi;
    e = 63;
    while (e > 0 && !x[e]) e--;
    if (e >= 32) nf = (x >> (e - 32)) & 64'hFFFF_FFFF;
    else nf = (x << (32 - e)) & 64'hFFFF_FFFF;
    rem = nf & ((64'd1 << (32 - TabBits)) - 1);
    lo = lg_tab[nf >> (32 - TabBits)];
    hi = lg_tab[(nf >> (32 - TabBits)) + 1];
    return longint'((64'(e) << 24) + lo + (((hi - lo) * rem) >> (32 - TabBits)));
  endfunction

  // adds one sample; returns 1 with the reading when the group closes
  function automatic bit fold_sample(input logic [11:0] s, output reading_t rd);
    logic [63:0] n, vc, rl, r0, fs, avg, v, rs, ratio, ppm, q, rem, yi, fr, rm, mt;
    longint      l, p, y;
    bit          rs_ok, ppm_ok;
    int          idx;
    n  = (spr_q != 0) ? spr_q : 64'd16;
    vc = (vc_q != 0) ? vc_q : 64'd327680;
    rl = (rl_q != 0) ? rl_q : 64'd655360;
    r0 = (r0_q != 0) ? r0_q : 64'd655360;
    rs = 0; ratio = 0; ppm = 0; rs_ok = 0; ppm_ok = 0;
    rd = '0;
    grp_sum = grp_sum + 28'(s);
    grp_cnt = grp_cnt + 16'd1;
    if (grp_cnt < n) return 0;
    avg = grp_sum / n;
    if (avg > 4095) avg = 4095;
    grp_sum = '0;
    grp_cnt = '0;
    case (code_q)
      2'd0:    fs = 511;
      2'd1:    fs = 1023;
      2'd2:    fs = 2047;
      default: fs = 4095;
    endcase
    v = ((avg * 4851) << 16) / (1000 * fs);
    // voltage window: above 1 mV and below the supply
    if (v * 1000 > 64'd65536 && v < vc) begin
      rs_ok = 1;
      rs = ((vc - v) * rl) / v;
      if (rs > 64'hFF_FFFF_FFFF) rs = 64'hFF_FFFF_FFFF;
      q = rs / r0;
      rem = rs % r0;
      if ((q >> 16) != 0) ratio = 64'hFFFF_FFFF;
      else begin
        ratio = (q << 16) + ((rem << 16) / r0);
        if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
      end
      // Rs must exceed 1 ohm-ish floor before the power law is evaluated
      if (rs * 1000 > 64'd65536) begin
        l = log2_q24(r0 * 756469) - log2_q24(rs) - (longint'(16) <<< 24);
        p = l * 42920;
        if (p >= 0) y = p >>> 16;
        else y = -((-p + 65535) >>> 16);
        y = y + (longint'(16) <<< 24);
        ppm_ok = 1;
        if (y >= 0) begin
          yi = 64'(y) >> 24;
          fr = 64'(y) & 64'hFF_FFFF;
          idx = int'(fr >> (24 - TabBits));
          rm = fr & ((64'd1 << (24 - TabBits)) - 1);
          mt = ex_tab[idx] + (((ex_tab[idx+1] - ex_tab[idx]) * rm) >> (24 - TabBits));
          if (yi >= 32) begin
            ppm = 64'hFFFF_FFFF;
            ppm_ok = 0;
          end else begin
            ppm = (yi >= 30) ? (mt << (yi - 30)) : (mt >> (30 - yi));
            if (ppm > 64'hFFFF_FFFF) begin
              ppm = 64'hFFFF_FFFF;
              ppm_ok = 0;
            end
          end
        end
      end
    end
    rd.avg    = avg[11:0];
    rd.volts  = (v > 64'h7FFFF) ? 19'h7FFFF : v[18:0];
    rd.rs     = rs[39:0];
    rd.ratio  = ratio[31:0];
    rd.ppm    = ppm[31:0];
    rd.rs_ok  = rs_ok;
    rd.ppm_ok = ppm_ok;
    return 1;
  endfunction

  task automatic note_fail(input reading_t want, input reading_t got, input bit orphan);
    if (fail_count_o < 10) begin
      if (orphan) $display("ERROR: reading with none pending: %p", got);
      else $display("ERROR: reading mismatch\n  exp %p\n  got %p", want, got);
    end
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t rd;
    reading_t got;
    if (!rst_ni) begin
      grp_sum = '0;
      grp_cnt = '0;
      spr_q   = SamplesRst;
      code_q  = AdcCodeRst;
      vc_q    = SupplyRst;
      rl_q    = LoadRst;
      r0_q    = CleanRst;
      readings_due.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegSamples:  spr_q  = cfg_data_i[15:0];
          RegAdcWidth: code_q = cfg_data_i[1:0];
          RegSupply:   vc_q   = cfg_data_i[19:0];
          RegLoad:     rl_q   = cfg_data_i;
          RegCleanAir: r0_q   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i && fold_sample(sample_i, rd)) readings_due.push_back(rd);
      if (out_valid_i && out_ready_i) begin
        got = '{avg_raw_i, sensor_volts_i, rs_kohm_i, rs_ratio_i, ppm_value_i,
                rs_valid_i, ppm_valid_i};
        if (readings_due.size() == 0) note_fail(got, got, 1'b1);
        else begin
          rd = readings_due.pop_front();
          if (got !== rd) note_fail(rd, got, 1'b0);
        end
      end
    end
    pending_o = readings_due.size();
  end

endmodule

/* sim/tb_top.sv */
// Stimulus, clock, reset and verdict for the gas sensor averaging and ppm unit.
module tb_top import gsa_pkg::*;;

  localparam int CycleLimit = 4_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [11:0] sample_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [11:0] avg_raw_o;
  logic [18:0] sensor_volts_o;
  logic [39:0] rs_kohm_o;
  logic [31:0] rs_ratio_o;
  logic [31:0] ppm_value_o;
  logic        rs_valid_o;
  logic        ppm_valid_o;

  int fail_count;
  int pending;
  int cycles;
  int sender_idle_pct;
  int sink_stall_pct;

  always #4 clk_i = ~clk_i;

  gas_sensor_average_and_ppm_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sample_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .out_valid_o, .out_ready_i, .avg_raw_o, .sensor_volts_o, .rs_kohm_o,
    .rs_ratio_o, .ppm_value_o, .rs_valid_o, .ppm_valid_o
  );

  gsa_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .sample_i,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .avg_raw_i(avg_raw_o),
    .sensor_volts_i(sensor_volts_o), .rs_kohm_i(rs_kohm_o), .rs_ratio_i(rs_ratio_o),
    .ppm_value_i(ppm_value_o), .rs_valid_i(rs_valid_o), .ppm_valid_i(ppm_valid_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side back-pressure
  always @(negedge clk_i) out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct);

  // one sample transfer; valid stays up across back-to-back transfers
  task automatic push_sample(input logic [11:0] s);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    @(negedge clk_i);
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // drain all readings, then give the sequencer time to go idle
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic load_cfg(input logic [23:0] spr, input logic [23:0] code,
                          input logic [23:0] vc, input logic [23:0] rl,
                          input logic [23:0] r0);
    settle();
    write_reg(RegSamples, spr);
    write_reg(RegAdcWidth, code);
    write_reg(RegSupply, vc);
    write_reg(RegLoad, rl);
    write_reg(RegCleanAir, r0);
  endtask

  // mix of low codes, high codes and full-range values
  function automatic logic [11:0] pick_sample();
    case ($urandom_range(0, 3))
      0:       return 12'($urandom_range(0, 15));
      1:       return 12'($urandom_range(3900, 4095));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin
    logic [23:0] rl;
    logic [23:0] r0;
    logic [11:0] corner_samples [6];
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    cycles = 0;
    corner_samples = '{12'd0, 12'd1, 12'd13, 12'd2048, 12'd3000, 12'd4095};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single-sample readings at reset-like settings: window floor, full scale, mid range
    load_cfg(24'd1, 24'd3, 24'd327680, 24'd655360, 24'd655360);
    foreach (corner_samples[i]) push_sample(corner_samples[i]);
    // average above full scale, huge Rs with tiny R0 -> ratio saturates, ppm underflows
    load_cfg(24'd1, 24'd0, 24'hFFFFF, 24'hFFFFFF, 24'd1);
    push_sample(12'd4095);
    push_sample(12'd511);
    push_sample(12'd1);
    push_sample(12'd600);
    // voltage at or above supply
    load_cfg(24'd1, 24'd2, 24'd1, 24'd1, 24'hFFFFFF);
    push_sample(12'd100);
    // voltage just under supply: Rs too small for the power law
    load_cfg(24'd1, 24'd3, 24'd232906, 24'd1, 24'hFFFFFF);
    push_sample(12'd3000);
    settle();
    write_reg(RegLoad, 24'hFFFFFF);
    push_sample(12'd3000);
    // group count lowered mid-group: emits at once, average saturates
    load_cfg(24'd8, 24'd3, 24'd327680, 24'd655360, 24'd655360);
    repeat (5) push_sample(12'd4095);
    settle();
    write_reg(RegSamples, 24'd2);
    push_sample(12'd4095);
    // zero registers fall back to reset values; unused index is ignored
    load_cfg(24'd0, 24'd3, 24'd0, 24'd0, 24'd0);
    write_reg(3'd7, 24'hFFFFFF);
    repeat (16) push_sample(pick_sample());

    // random settings, cycling through the idle/stall profiles
    for (int ph = 0; ph < 12; ph++) begin
      rl = 24'($urandom) >> $urandom_range(0, 16);
      r0 = 24'($urandom) >> $urandom_range(0, 16);
      load_cfg(24'($urandom) & 24'hFF0000 | 24'($urandom_range(1, (ph == 5) ? 16 : 4)),
               24'($urandom),
               ($urandom_range(0, 1) != 0) ? 24'($urandom) : 24'($urandom_range(200000, 400000)),
               rl, r0);
      case (ph % 4)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 48; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 48; end
        default: begin sender_idle_pct = 21; sink_stall_pct = 21; end
      endcase
      repeat (85) push_sample(pick_sample());
    end

    // one full group of full-scale samples at reset settings
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    load_cfg(24'd16, 24'd3, 24'd327680, 24'd655360, 24'd655360);
    repeat (16) push_sample(12'd4095);

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
